// ----- hdl/srq_pkg.sv -----
// Shared constants, types and helpers of the sanitizing record queue.
package srq_pkg;

    localparam int SLOTS     = 16;
    localparam int CAT_BYTES = 16;
    localparam int PAY_BYTES = 32;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = 5;
    localparam int CK_W    = $clog2(CAT_BYTES);
    localparam int PK_W    = $clog2(PAY_BYTES);
    localparam int IDX_W   = (PK_W > CK_W) ? PK_W : CK_W;
    localparam int CAT_AW  = $clog2(SLOTS * CAT_BYTES);
    localparam int PAY_AW  = $clog2(SLOTS * PAY_BYTES);
    localparam int FIFO_DEPTH = 2;

    localparam logic [1:0] CFG_SLOTS  = 2'd0;
    localparam logic [1:0] CFG_PAYCAP = 2'd1;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        K_ENQ     = 3'd0,
        K_FULL    = 3'd1,
        K_EMPTY   = 3'd2,
        K_BYTE    = 3'd3,
        K_NOBYTES = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_ACCEPT,
        AS_REJECT
    } t_asm;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_CAT,
        BS_PAY
    } t_bst;

    typedef struct packed {
        t_kind              kind;
        logic [CNT_W-1:0]   depth;
        logic [CNT_W-1:0]   peak;
        logic [31:0]        seq;
        logic [7:0]         level;
        logic [63:0]        time_ms;
        logic [15:0]        cat_len;
        logic [15:0]        pay_len;
        logic [SLOT_W-1:0]  slot;
        logic [CK_W-1:0]    cat_kept;
        logic [PK_W-1:0]    pay_kept;
    } t_job;

    function automatic logic [7:0] sanitize(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_NL || c == CH_CR || c == CH_TAB) begin
            r = CH_SPACE;
        end
        return r;
    endfunction

endpackage

// ----- hdl/sanitizing_record_queue_top.sv -----
// Sanitizing record queue: a bounded ring of log records with byte-wise text.
// Usage: an item is taken when i_start is high and o_busy is low. Enqueue items
// (i_cmd low) carry up to one text byte each; the first item of a record takes
// level and time and checks for a free slot, the item with i_record_end gives one
// result (enqueued or full). A dequeue item (i_cmd high) gives the oldest
// record's bytes, category first, one per cycle, or a single result when the
// queue is empty or the record holds no text.
// Results appear on the o_ ports for one cycle with o_valid high; o_last marks
// the final result of a run. The receiver cannot hold results off.
// Timing: enqueue items are taken one per cycle while o_busy is low; results pass
// through the job queue and an output register. A dequeue with bytes keeps o_busy
// high until its last byte; each memory's single read port walks one byte per cycle.
// The configuration channel (i_cfg_valid/o_cfg_ready, index, data) is always
// ready; writing the slot count empties the queue. Reset (i_rst_n low, synchronous)
// empties the queue and restores 16 slots and a payload capacity of 32.
module sanitizing_record_queue_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cmd,
    input  logic              i_part,
    input  logic              i_has_byte,
    input  logic [7:0]        i_data_byte,
    input  logic              i_record_end,
    input  logic signed [7:0] i_level,
    input  logic [63:0]       i_wall_time_ms,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [5:0]        i_cfg_data,
    output logic              o_valid,
    output logic [2:0]        o_kind,
    output logic [4:0]        o_depth,
    output logic [4:0]        o_high_watermark,
    output logic [31:0]       o_sequence_res,
    output logic signed [7:0] o_out_level,
    output logic [63:0]       o_out_time_ms,
    output logic [15:0]       o_cat_total,
    output logic [15:0]       o_pay_total,
    output logic              o_out_part,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);
    logic cat_we, pay_we, cat_re, pay_re;
    logic [srq_pkg::CAT_AW-1:0] cat_waddr, cat_raddr;
    logic [srq_pkg::PAY_AW-1:0] pay_waddr, pay_raddr;
    logic [7:0] cat_wdata, pay_wdata, cat_rdata, pay_rdata;
    logic push, pop, fifo_full, fifo_empty, deq_done;
    srq_pkg::t_job push_job, head_job;

    srq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cmd(i_cmd), .i_part(i_part), .i_has_byte(i_has_byte),
        .i_data_byte(i_data_byte), .i_record_end(i_record_end), .i_level(i_level),
        .i_wall_time_ms(i_wall_time_ms), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_cat_we(cat_we), .o_cat_waddr(cat_waddr), .o_cat_wdata(cat_wdata),
        .o_pay_we(pay_we), .o_pay_waddr(pay_waddr), .o_pay_wdata(pay_wdata),
        .o_push(push), .o_job(push_job), .i_fifo_full(fifo_full), .i_deq_done(deq_done)
    );

    srq_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(push_job),
        .i_pop(pop), .o_job(head_job), .o_full(fifo_full), .o_empty(fifo_empty)
    );

    srq_ram #(.WIDTH(8), .DEPTH(srq_pkg::SLOTS * srq_pkg::CAT_BYTES)) u_cat_ram (
        .i_clk(i_clk), .i_we(cat_we), .i_waddr(cat_waddr), .i_wdata(cat_wdata),
        .i_re(cat_re), .i_raddr(cat_raddr), .o_rdata(cat_rdata)
    );

    srq_ram #(.WIDTH(8), .DEPTH(srq_pkg::SLOTS * srq_pkg::PAY_BYTES)) u_pay_ram (
        .i_clk(i_clk), .i_we(pay_we), .i_waddr(pay_waddr), .i_wdata(pay_wdata),
        .i_re(pay_re), .i_raddr(pay_raddr), .o_rdata(pay_rdata)
    );

    srq_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(head_job), .i_empty(fifo_empty),
        .o_pop(pop), .o_cat_re(cat_re), .o_cat_raddr(cat_raddr), .i_cat_rdata(cat_rdata),
        .o_pay_re(pay_re), .o_pay_raddr(pay_raddr), .i_pay_rdata(pay_rdata),
        .o_deq_done(deq_done), .o_valid(o_valid), .o_kind(o_kind), .o_depth(o_depth),
        .o_high_watermark(o_high_watermark), .o_sequence_res(o_sequence_res),
        .o_out_level(o_out_level), .o_out_time_ms(o_out_time_ms),
        .o_cat_total(o_cat_total), .o_pay_total(o_pay_total),
        .o_out_part(o_out_part), .o_out_byte(o_out_byte), .o_last(o_last)
    );

    a_depth_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_depth <= o_high_watermark))
        else $error("depth above high watermark");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == srq_pkg::K_EMPTY) |-> (o_last && o_depth == 5'd0))
        else $error("empty dequeue result malformed");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_full |-> !push)
        else $error("job pushed into a full queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");
endmodule

// ----- hdl/srq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/srq_fifo.sv -----
// Short job queue between the front and the back of the record queue.
module srq_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srq_pkg::t_job i_job,
    input  logic          i_pop,
    output srq_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    localparam int PW = (srq_pkg::FIFO_DEPTH > 1) ? $clog2(srq_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(srq_pkg::FIFO_DEPTH + 1);

    srq_pkg::t_job r_q [srq_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PW'(srq_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= bump(r_wp);
            end
            if (i_pop) begin
                r_rp <= bump(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    assign o_job   = r_q[r_rp];
    assign o_full  = (r_cnt == CW'(srq_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
endmodule

// ----- hdl/srq_front.sv -----
// Front part: accepts items, keeps the ring cursors and metadata, stores text.
module srq_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_cmd,
    input  logic                        i_part,
    input  logic                        i_has_byte,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_record_end,
    input  logic signed [7:0]           i_level,
    input  logic [63:0]                 i_wall_time_ms,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [5:0]                  i_cfg_data,
    output logic                        o_cat_we,
    output logic [srq_pkg::CAT_AW-1:0]  o_cat_waddr,
    output logic [7:0]                  o_cat_wdata,
    output logic                        o_pay_we,
    output logic [srq_pkg::PAY_AW-1:0]  o_pay_waddr,
    output logic [7:0]                  o_pay_wdata,
    output logic                        o_push,
    output srq_pkg::t_job               o_job,
    input  logic                        i_fifo_full,
    input  logic                        i_deq_done
);
    localparam int SW = srq_pkg::SLOT_W;
    localparam int NW = srq_pkg::CNT_W;
    localparam int KW = srq_pkg::CK_W;
    localparam int PW = srq_pkg::PK_W;

    logic [4:0]    r_slots;
    logic [5:0]    r_paycap;
    logic [SW-1:0] r_ws, r_rs, n_ws, n_rs;
    logic [NW-1:0] r_held, r_peak, n_held, n_peak;
    logic [31:0]   r_next, n_next;
    srq_pkg::t_asm r_asm, n_asm;
    logic [15:0]   r_cc, r_pc, n_cc, n_pc;
    logic [KW-1:0] r_ck, n_ck;
    logic [PW-1:0] r_pk, n_pk;
    logic [7:0]    r_cur_level, n_cur_level;
    logic [63:0]   r_cur_time, n_cur_time;
    logic          r_deq_busy;

    logic [31:0]   r_m_seq  [srq_pkg::SLOTS];
    logic [63:0]   r_m_time [srq_pkg::SLOTS];
    logic [7:0]    r_m_lvl  [srq_pkg::SLOTS];
    logic [15:0]   r_m_cl   [srq_pkg::SLOTS];
    logic [15:0]   r_m_pl   [srq_pkg::SLOTS];
    logic [KW-1:0] r_m_ck   [srq_pkg::SLOTS];
    logic [PW-1:0] r_m_pk   [srq_pkg::SLOTS];

    logic       accept, enq, deq, first, acc, meta_we;
    logic       cfg_we, cfg_flush;
    logic [4:0] eff;
    logic [5:0] pcap, plim;

    assign o_busy      = r_deq_busy || i_fifo_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;
    assign enq         = accept && !i_cmd;
    assign deq         = accept && i_cmd;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_flush   = cfg_we && (i_cfg_index == srq_pkg::CFG_SLOTS);
    assign first       = (r_asm == srq_pkg::AS_IDLE);

    always_comb begin
        eff = r_slots;
        if (r_slots == 5'd0) begin
            eff = 5'd1;
        end else if (r_slots > 5'(srq_pkg::SLOTS)) begin
            eff = 5'(srq_pkg::SLOTS);
        end
        pcap = (r_paycap > 6'(srq_pkg::PAY_BYTES)) ? 6'(srq_pkg::PAY_BYTES) : r_paycap;
        plim = (pcap == 6'd0) ? 6'd0 : pcap - 6'd1;
    end

    assign acc = first ? (r_held < eff) : (r_asm == srq_pkg::AS_ACCEPT);

    // Run tracking.
    always_comb begin
        n_asm = r_asm;
        if (cfg_flush) begin
            n_asm = srq_pkg::AS_IDLE;
        end else if (enq) begin
            if (i_record_end) begin
                n_asm = srq_pkg::AS_IDLE;
            end else begin
                n_asm = acc ? srq_pkg::AS_ACCEPT : srq_pkg::AS_REJECT;
            end
        end
    end

    // Counting, text stores, cursors and job building.
    always_comb begin
        n_ws        = r_ws;
        n_rs        = r_rs;
        n_held      = r_held;
        n_peak      = r_peak;
        n_next      = r_next;
        n_cc        = r_cc;
        n_pc        = r_pc;
        n_ck        = r_ck;
        n_pk        = r_pk;
        n_cur_level = r_cur_level;
        n_cur_time  = r_cur_time;
        o_cat_we    = 1'b0;
        o_pay_we    = 1'b0;
        o_cat_waddr = '0;
        o_pay_waddr = '0;
        o_cat_wdata = srq_pkg::sanitize(i_data_byte);
        o_pay_wdata = srq_pkg::sanitize(i_data_byte);
        o_push      = 1'b0;
        o_job       = '0;
        meta_we     = 1'b0;
        if (cfg_flush) begin
            n_ws   = '0;
            n_rs   = '0;
            n_held = '0;
            n_cc   = '0;
            n_pc   = '0;
        end else if (enq) begin
            if (first) begin
                n_cc        = '0;
                n_pc        = '0;
                n_ck        = '0;
                n_pk        = '0;
                n_cur_level = i_level;
                n_cur_time  = i_wall_time_ms;
            end
            if (i_has_byte && !i_part) begin
                if (n_cc != 16'hFFFF) begin
                    n_cc = n_cc + 16'd1;
                end
                if (acc && (n_ck < KW'(srq_pkg::CAT_BYTES - 1))) begin
                    o_cat_we    = 1'b1;
                    o_cat_waddr = srq_pkg::CAT_AW'(r_ws) *
                                  srq_pkg::CAT_AW'(srq_pkg::CAT_BYTES) +
                                  srq_pkg::CAT_AW'(n_ck);
                    n_ck        = n_ck + 1'b1;
                end
            end
            if (i_has_byte && i_part) begin
                if (n_pc != 16'hFFFF) begin
                    n_pc = n_pc + 16'd1;
                end
                if (acc && (6'(n_pk) < plim)) begin
                    o_pay_we    = 1'b1;
                    o_pay_waddr = srq_pkg::PAY_AW'(r_ws) *
                                  srq_pkg::PAY_AW'(srq_pkg::PAY_BYTES) +
                                  srq_pkg::PAY_AW'(n_pk);
                    n_pk        = n_pk + 1'b1;
                end
            end
            if (i_record_end) begin
                o_push        = 1'b1;
                o_job.cat_len = n_cc;
                o_job.pay_len = n_pc;
                if (acc) begin
                    meta_we     = 1'b1;
                    o_job.kind  = srq_pkg::K_ENQ;
                    o_job.seq   = r_next;
                    n_next      = r_next + 32'd1;
                    n_ws        = (5'(r_ws) + 5'd1 >= eff) ? '0 : r_ws + 1'b1;
                    n_held      = r_held + 1'b1;
                    n_peak      = (n_held > r_peak) ? n_held : r_peak;
                end else begin
                    o_job.kind  = srq_pkg::K_FULL;
                end
                o_job.depth = n_held;
                o_job.peak  = n_peak;
            end
        end else if (deq) begin
            o_push = 1'b1;
            if (r_held == '0) begin
                o_job.kind  = srq_pkg::K_EMPTY;
                o_job.depth = r_held;
                o_job.peak  = r_peak;
            end else begin
                n_held         = r_held - 1'b1;
                n_rs           = (5'(r_rs) + 5'd1 >= eff) ? '0 : r_rs + 1'b1;
                o_job.kind     = (r_m_ck[r_rs] == '0 && r_m_pk[r_rs] == '0) ?
                                 srq_pkg::K_NOBYTES : srq_pkg::K_BYTE;
                o_job.depth    = n_held;
                o_job.peak     = r_peak;
                o_job.seq      = r_m_seq[r_rs];
                o_job.level    = r_m_lvl[r_rs];
                o_job.time_ms  = r_m_time[r_rs];
                o_job.cat_len  = r_m_cl[r_rs];
                o_job.pay_len  = r_m_pl[r_rs];
                o_job.slot     = r_rs;
                o_job.cat_kept = r_m_ck[r_rs];
                o_job.pay_kept = r_m_pk[r_rs];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots    <= 5'd16;
            r_paycap   <= 6'd32;
            r_ws       <= '0;
            r_rs       <= '0;
            r_held     <= '0;
            r_peak     <= '0;
            r_next     <= '0;
            r_asm      <= srq_pkg::AS_IDLE;
            r_cc       <= '0;
            r_pc       <= '0;
            r_ck       <= '0;
            r_pk       <= '0;
            r_deq_busy <= 1'b0;
        end else begin
            if (cfg_flush) begin
                r_slots <= i_cfg_data[4:0];
            end
            if (cfg_we && i_cfg_index == srq_pkg::CFG_PAYCAP) begin
                r_paycap <= i_cfg_data;
            end
            r_ws   <= n_ws;
            r_rs   <= n_rs;
            r_held <= n_held;
            r_peak <= n_peak;
            r_next <= n_next;
            r_asm  <= n_asm;
            r_cc   <= n_cc;
            r_pc   <= n_pc;
            r_ck   <= n_ck;
            r_pk   <= n_pk;
            if (o_push && o_job.kind == srq_pkg::K_BYTE) begin
                r_deq_busy <= 1'b1;
            end else if (i_deq_done) begin
                r_deq_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_level <= n_cur_level;
        r_cur_time  <= n_cur_time;
        if (meta_we) begin
            r_m_seq[r_ws]  <= r_next;
            r_m_time[r_ws] <= n_cur_time;
            r_m_lvl[r_ws]  <= n_cur_level;
            r_m_cl[r_ws]   <= n_cc;
            r_m_pl[r_ws]   <= n_pc;
            r_m_ck[r_ws]   <= n_ck;
            r_m_pk[r_ws]   <= n_pk;
        end
    end
endmodule

// ----- hdl/srq_back.sv -----
// Back part: takes jobs from the queue and emits results, reading text bytes.
module srq_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srq_pkg::t_job               i_job,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_cat_re,
    output logic [srq_pkg::CAT_AW-1:0]  o_cat_raddr,
    input  logic [7:0]                  i_cat_rdata,
    output logic                        o_pay_re,
    output logic [srq_pkg::PAY_AW-1:0]  o_pay_raddr,
    input  logic [7:0]                  i_pay_rdata,
    output logic                        o_deq_done,
    output logic                        o_valid,
    output logic [2:0]                  o_kind,
    output logic [4:0]                  o_depth,
    output logic [4:0]                  o_high_watermark,
    output logic [31:0]                 o_sequence_res,
    output logic signed [7:0]           o_out_level,
    output logic [63:0]                 o_out_time_ms,
    output logic [15:0]                 o_cat_total,
    output logic [15:0]                 o_pay_total,
    output logic                        o_out_part,
    output logic [7:0]                  o_out_byte,
    output logic                        o_last
);
    localparam int XW = srq_pkg::IDX_W + 1;

    srq_pkg::t_bst r_st, n_st;
    logic [srq_pkg::IDX_W-1:0] r_idx, n_idx;
    srq_pkg::t_job r_job, r_out_job;
    logic r_out_v, r_out_last, r_out_isbyte, r_out_part;
    logic single, cat_end, pay_end, final_rd;

    assign o_pop   = (r_st == srq_pkg::BS_IDLE) && !i_empty;
    assign single  = o_pop && (i_job.kind != srq_pkg::K_BYTE);
    assign cat_end = (XW'(r_idx) + XW'(1)) == XW'(r_job.cat_kept);
    assign pay_end = (XW'(r_idx) + XW'(1)) == XW'(r_job.pay_kept);

    always_comb begin
        n_st  = r_st;
        n_idx = r_idx;
        unique case (r_st)
            srq_pkg::BS_IDLE: begin
                if (o_pop && i_job.kind == srq_pkg::K_BYTE) begin
                    n_st  = (i_job.cat_kept != '0) ? srq_pkg::BS_CAT : srq_pkg::BS_PAY;
                    n_idx = '0;
                end
            end
            srq_pkg::BS_CAT: begin
                if (cat_end) begin
                    n_st  = (r_job.pay_kept != '0) ? srq_pkg::BS_PAY : srq_pkg::BS_IDLE;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            srq_pkg::BS_PAY: begin
                if (pay_end) begin
                    n_st = srq_pkg::BS_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_st = srq_pkg::BS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cat_re    = (r_st == srq_pkg::BS_CAT);
        o_pay_re    = (r_st == srq_pkg::BS_PAY);
        o_cat_raddr = srq_pkg::CAT_AW'(r_job.slot) *
                      srq_pkg::CAT_AW'(srq_pkg::CAT_BYTES) + srq_pkg::CAT_AW'(r_idx);
        o_pay_raddr = srq_pkg::PAY_AW'(r_job.slot) *
                      srq_pkg::PAY_AW'(srq_pkg::PAY_BYTES) + srq_pkg::PAY_AW'(r_idx);
        final_rd    = (o_cat_re && cat_end && r_job.pay_kept == '0) ||
                      (o_pay_re && pay_end);
        o_deq_done  = final_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= srq_pkg::BS_IDLE;
            r_idx   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_idx   <= n_idx;
            r_out_v <= single || o_cat_re || o_pay_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        r_out_job    <= single ? i_job : r_job;
        r_out_last   <= single || final_rd;
        r_out_isbyte <= !single && (o_cat_re || o_pay_re);
        r_out_part   <= o_pay_re;
    end

    assign o_valid           = r_out_v;
    assign o_kind            = r_out_job.kind;
    assign o_depth           = r_out_job.depth;
    assign o_high_watermark  = r_out_job.peak;
    assign o_sequence_res    = r_out_job.seq;
    assign o_out_level       = r_out_job.level;
    assign o_out_time_ms     = r_out_job.time_ms;
    assign o_cat_total       = r_out_job.cat_len;
    assign o_pay_total       = r_out_job.pay_len;
    assign o_out_part        = r_out_isbyte && r_out_part;
    assign o_out_byte        = !r_out_isbyte ? 8'd0 :
                               (r_out_part ? i_pay_rdata : i_cat_rdata);
    assign o_last            = r_out_last;
endmodule
